### sv/dctc_pkg.sv
package dctc_pkg;

	localparam int DELAY_W = 10;

	typedef enum logic [1:0] {
		CMD_ACTIVATE  = 2'd0,
		CMD_PRECHARGE = 2'd1,
		CMD_READ      = 2'd2,
		CMD_WRITE     = 2'd3
	} cmd_type_t;

	typedef enum logic [1:0] {
		REG_ACTIVATE_TIMING = 2'd0,
		REG_ACCESS_TIMING   = 2'd1,
		REG_WRITE_TIMING    = 2'd2,
		REG_BURST_LENGTH    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] rrd;
		logic [7:0] rc;
		logic [7:0] rp;
		logic [7:0] ras;
		logic [7:0] ccd;
		logic [7:0] rcd_rd;
		logic [7:0] rcd_wr;
		logic [7:0] rtw;
		logic [7:0] rtp;
		logic [7:0] wr;
		logic [7:0] wl;
		logic [7:0] wtr;
		logic [7:0] burst;
	} timing_t;

endpackage

### sv/dctc_hist.sv
module dctc_hist #(
	parameter int DEPTH     = 16,
	parameter int AW        = 4,
	parameter int TIME_BITS = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [TIME_BITS-1:0] wr_data,
	output logic [TIME_BITS-1:0] rd_data
);

	logic [TIME_BITS-1:0] mem [DEPTH];
	logic [DEPTH-1:0]     vld_q;
	logic [TIME_BITS-1:0] mem_rd_s1;
	logic [TIME_BITS-1:0] fwd_s1;
	logic                 hit_s1;
	logic                 ent_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_s1 <= mem[rd_addr];
			fwd_s1    <= wr_data;
		end
	end

	// A write in the same cycle as the read is forwarded, since the memory returns the old word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			hit_s1     <= 1'b0;
			ent_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_s1     <= wr_en && (wr_addr == rd_addr);
				ent_vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = hit_s1 ? fwd_s1 : (ent_vld_s1 ? mem_rd_s1 : '0);

endmodule

### sv/dctc_rules.sv
module dctc_rules #(
	parameter int TIME_BITS = 48
) (
	input  dctc_pkg::timing_t    timing,
	input  dctc_pkg::cmd_type_t  cmd_type,
	input  logic                 in_range,
	input  logic [TIME_BITS-1:0] now,
	input  logic [TIME_BITS-1:0] last_act_any,
	input  logic [TIME_BITS-1:0] last_rd_any,
	input  logic [TIME_BITS-1:0] last_wr_any,
	input  logic [TIME_BITS-1:0] bank_act,
	input  logic [TIME_BITS-1:0] bank_pre,
	input  logic [TIME_BITS-1:0] bank_rd,
	input  logic [TIME_BITS-1:0] bank_wr,
	input  logic                 bank_accessed,
	output logic                 met
);

	logic [dctc_pkg::DELAY_W-1:0] wr_rec_dly;
	logic [dctc_pkg::DELAY_W-1:0] wtr_dly;
	logic [dctc_pkg::DELAY_W-1:0] ras_rp_dly;
	logic ok_rrd, ok_rc, ok_rp, ok_rtp, ok_wrec, ok_ras;
	logic ok_ccd_rd, ok_ccd_wr, ok_rcd_rd, ok_rcd_wr, ok_wtr, ok_rtw;

	function automatic logic after_t(input logic [TIME_BITS-1:0] t_now,
	                                 input logic [TIME_BITS-1:0] t_last,
	                                 input logic [dctc_pkg::DELAY_W-1:0] dly);
		logic [TIME_BITS-1:0] diff;
		diff    = t_now - t_last;
		after_t = (t_now >= t_last) && (diff >= TIME_BITS'(dly));
	endfunction

	assign wr_rec_dly = dctc_pkg::DELAY_W'(timing.wr) + dctc_pkg::DELAY_W'(timing.wl)
	                  + dctc_pkg::DELAY_W'(timing.burst);
	assign wtr_dly    = dctc_pkg::DELAY_W'(timing.wtr) + dctc_pkg::DELAY_W'(timing.wl)
	                  + dctc_pkg::DELAY_W'(timing.burst);
	assign ras_rp_dly = dctc_pkg::DELAY_W'(timing.ras) + dctc_pkg::DELAY_W'(timing.rp);

	assign ok_rrd    = after_t(now, last_act_any, dctc_pkg::DELAY_W'(timing.rrd));
	assign ok_rc     = after_t(now, bank_act, dctc_pkg::DELAY_W'(timing.rc));
	assign ok_rp     = after_t(now, bank_pre, dctc_pkg::DELAY_W'(timing.rp));
	assign ok_rtp    = after_t(now, last_rd_any, dctc_pkg::DELAY_W'(timing.rtp));
	assign ok_wrec   = after_t(now, bank_wr, wr_rec_dly);
	assign ok_ras    = after_t(now, bank_act, ras_rp_dly);
	assign ok_ccd_rd = after_t(now, last_rd_any, dctc_pkg::DELAY_W'(timing.ccd));
	assign ok_ccd_wr = after_t(now, last_wr_any, dctc_pkg::DELAY_W'(timing.ccd));
	assign ok_rcd_rd = bank_accessed || after_t(now, bank_act, dctc_pkg::DELAY_W'(timing.rcd_rd));
	assign ok_rcd_wr = bank_accessed || after_t(now, bank_act, dctc_pkg::DELAY_W'(timing.rcd_wr));
	assign ok_wtr    = after_t(now, bank_wr, wtr_dly);
	assign ok_rtw    = after_t(now, bank_rd, dctc_pkg::DELAY_W'(timing.rtw));

	always_comb begin
		case (cmd_type)
			dctc_pkg::CMD_ACTIVATE: begin
				met = ok_rrd && ok_rc && ok_rp;
			end
			dctc_pkg::CMD_PRECHARGE: begin
				met = ok_rtp && ok_wrec && ok_ras;
			end
			dctc_pkg::CMD_READ: begin
				met = ok_ccd_rd && ok_rcd_rd && ok_wtr;
			end
			default: begin
				met = ok_ccd_wr && ok_rtw && ok_rcd_wr;
			end
		endcase
		met = met && in_range;
	end

endmodule

### sv/dram_command_timing_checker_core.sv
// Requests pass through the input register and then the result register.
// Throughput: one request per cycle unless the result stalls; the two registers decouple
// the two sides, and a request checks against the history left by the one before it.
// Per-bank history sits in one small memory per command type, read when a request is taken.
// Reset clears the timing registers, the per-type times, the access flags and the per-bank
// valid bits, so history reads as zero at once with no clearing pass.
module dram_command_timing_checker_core #(
	parameter int BANK_COUNT = 16,
	parameter int TIME_BITS = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// command [0], cmd_type [2:1], bank [6:3], current_time [TIME_BITS+6:7], zero padding
	input  logic [((TIME_BITS+14)/8)*8-1:0] s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// timing_met [0], zero padding [7:1]
	output logic [7:0]                    m_axis_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [39:0]                   cfg_data
);

	localparam int BANK_AW = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

	dctc_pkg::timing_t timing_q;

	logic                 accept_in;
	logic                 out_free;
	logic                 fire;
	logic                 rec;
	logic [BANK_AW-1:0]   in_addr;
	logic                 in_range;

	logic                 s1_vld_q;
	logic                 issue_s1;
	dctc_pkg::cmd_type_t  type_s1;
	logic [BANK_AW-1:0]   bank_s1;
	logic                 in_range_s1;
	logic [TIME_BITS-1:0] time_s1;

	logic [TIME_BITS-1:0] last_type_q [4];
	logic [BANK_COUNT-1:0] acc_q;

	logic [TIME_BITS-1:0] bank_act, bank_pre, bank_rd, bank_wr;
	logic                 met;
	logic                 m_valid_q;
	logic                 met_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q <= '0;
		end else if (cfg_valid) begin
			case (dctc_pkg::cfg_reg_t'(cfg_index))
				dctc_pkg::REG_ACTIVATE_TIMING: begin
					{timing_q.ras, timing_q.rp, timing_q.rc, timing_q.rrd} <= cfg_data[31:0];
				end
				dctc_pkg::REG_ACCESS_TIMING: begin
					{timing_q.rtp, timing_q.rtw, timing_q.rcd_wr, timing_q.rcd_rd,
					 timing_q.ccd} <= cfg_data;
				end
				dctc_pkg::REG_WRITE_TIMING: begin
					{timing_q.wtr, timing_q.wl, timing_q.wr} <= cfg_data[23:0];
				end
				default: begin
					timing_q.burst <= cfg_data[7:0];
				end
			endcase
		end
	end

	assign out_free      = !m_valid_q || m_axis_tready;
	assign fire          = s1_vld_q && out_free;
	assign s_axis_tready = !s1_vld_q || out_free;
	assign accept_in     = s_axis_tvalid && s_axis_tready;
	assign rec           = fire && issue_s1 && in_range_s1;
	assign in_addr       = BANK_AW'(s_axis_tdata[6:3]);
	assign in_range      = 32'(s_axis_tdata[6:3]) < BANK_COUNT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (accept_in) begin
			s1_vld_q <= 1'b1;
		end else if (fire) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			issue_s1    <= s_axis_tdata[0];
			type_s1     <= dctc_pkg::cmd_type_t'(s_axis_tdata[2:1]);
			bank_s1     <= in_addr;
			in_range_s1 <= in_range;
			time_s1     <= s_axis_tdata[TIME_BITS+6:7];
		end
	end

	// A precharge leaves the access flag of its bank as it is.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				last_type_q[i] <= '0;
			end
			acc_q <= '0;
		end else if (rec) begin
			last_type_q[type_s1] <= time_s1;
			if (type_s1 != dctc_pkg::CMD_PRECHARGE) begin
				acc_q[bank_s1] <= (type_s1 != dctc_pkg::CMD_ACTIVATE);
			end
		end
	end

	dctc_hist #(.DEPTH(BANK_COUNT), .AW(BANK_AW), .TIME_BITS(TIME_BITS)) u_hist_act (
		.clk, .arst_n, .rd_en(accept_in), .rd_addr(in_addr),
		.wr_en(rec && (type_s1 == dctc_pkg::CMD_ACTIVATE)), .wr_addr(bank_s1),
		.wr_data(time_s1), .rd_data(bank_act)
	);

	dctc_hist #(.DEPTH(BANK_COUNT), .AW(BANK_AW), .TIME_BITS(TIME_BITS)) u_hist_pre (
		.clk, .arst_n, .rd_en(accept_in), .rd_addr(in_addr),
		.wr_en(rec && (type_s1 == dctc_pkg::CMD_PRECHARGE)), .wr_addr(bank_s1),
		.wr_data(time_s1), .rd_data(bank_pre)
	);

	dctc_hist #(.DEPTH(BANK_COUNT), .AW(BANK_AW), .TIME_BITS(TIME_BITS)) u_hist_rd (
		.clk, .arst_n, .rd_en(accept_in), .rd_addr(in_addr),
		.wr_en(rec && (type_s1 == dctc_pkg::CMD_READ)), .wr_addr(bank_s1),
		.wr_data(time_s1), .rd_data(bank_rd)
	);

	dctc_hist #(.DEPTH(BANK_COUNT), .AW(BANK_AW), .TIME_BITS(TIME_BITS)) u_hist_wr (
		.clk, .arst_n, .rd_en(accept_in), .rd_addr(in_addr),
		.wr_en(rec && (type_s1 == dctc_pkg::CMD_WRITE)), .wr_addr(bank_s1),
		.wr_data(time_s1), .rd_data(bank_wr)
	);

	dctc_rules #(.TIME_BITS(TIME_BITS)) u_rules (
		.timing        (timing_q),
		.cmd_type      (type_s1),
		.in_range      (in_range_s1),
		.now           (time_s1),
		.last_act_any  (last_type_q[dctc_pkg::CMD_ACTIVATE]),
		.last_rd_any   (last_type_q[dctc_pkg::CMD_READ]),
		.last_wr_any   (last_type_q[dctc_pkg::CMD_WRITE]),
		.bank_act      (bank_act),
		.bank_pre      (bank_pre),
		.bank_rd       (bank_rd),
		.bank_wr       (bank_wr),
		.bank_accessed (acc_q[bank_s1]),
		.met           (met)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			met_q <= met;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'b0, met_q};

	// A request held behind a stalled result keeps its place and its time.
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld_q && !out_free |=> s1_vld_q && $stable(time_s1))
		else $error("held request lost or changed");

	// Every taken request reaches the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_valid_q)
		else $error("result not produced");

	// A bank outside the configured range never meets timing.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && !in_range_s1 |=> !met_q)
		else $error("out-of-range bank reported as met");

	// An issued activate clears the access flag of its bank.
	assert property (@(posedge clk) disable iff (!arst_n)
		rec && (type_s1 == dctc_pkg::CMD_ACTIVATE) |=> !acc_q[$past(bank_s1)])
		else $error("access flag not cleared by activate");

endmodule
